// File: design/double_hash_table_assert.svh
// Assertion macros for the double hash table checkers.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef DOUBLE_HASH_TABLE_ASSERT_SVH
`define DOUBLE_HASH_TABLE_ASSERT_SVH

// Same-cycle implication.
`define DHT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("double_hash_table check failed");

// Next-cycle implication.
`define DHT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("double_hash_table check failed");

`endif

// File: design/dht_pkg.sv
package dht_pkg;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 16;
  localparam int REC_W    = 32;
  localparam int SLOT_FW  = 3;   // slot and slot_index field width
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [REC_W-1:0]   record;
    logic [SLOT_FW-1:0] slot;
  } dht_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_FW-1:0]  slot_index;
    logic                slot_valid;
    logic [KEY_W-1:0]    key_out;
    logic [REC_W-1:0]    record_out;
    logic [CNT_W-1:0]    removed_count;
  } dht_result_t;

endpackage

// File: design/dht_queue.sv
module dht_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: design/dht_front.sv
module dht_front #(
  parameter int TABLE_SIZE   = 7,
  parameter int STEP_MODULUS = 5,
  parameter int SLOT_W       = 3,
  parameter int STEP_W       = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dht_pkg::dht_item_t in_item,
  output logic               push_valid,
  input  logic               push_ready,
  output dht_pkg::dht_item_t push_item,
  output logic [SLOT_W-1:0]  push_home,
  output logic [SLOT_W-1:0]  push_step
);

  import dht_pkg::*;

  // floor(2^32/M)+1: exact quotient for operands below 2^16, M below 2^8
  localparam logic [32:0] RECIP_TS = 33'((64'd1 << 32) / TABLE_SIZE + 1);
  localparam logic [32:0] RECIP_SM = 33'((64'd1 << 32) / STEP_MODULUS + 1);
  localparam int PKW = KEY_W + 33;
  localparam int PSW = STEP_W + 33;

  typedef enum logic [2:0] {F_IDLE, F_QUOT, F_REM, F_QUOT2, F_PUSH} fstate_t;

  fstate_t            state_r;
  dht_item_t          item_r;
  logic [KEY_W-1:0]   qh_r, qs_r;
  logic [STEP_W-1:0]  q2_r, step_r;
  logic [SLOT_W-1:0]  home_r;

  logic [PKW-1:0]     prod_h, prod_s;
  logic [PSW-1:0]     prod_2;
  logic [KEY_W-1:0]   rem_h, rem_s;
  logic [STEP_W-1:0]  step_raw, rem_2;

  assign prod_h   = PKW'(item_r.key) * PKW'(RECIP_TS);
  assign prod_s   = PKW'(item_r.key) * PKW'(RECIP_SM);
  assign rem_h    = item_r.key - KEY_W'(qh_r * KEY_W'(TABLE_SIZE));
  assign rem_s    = item_r.key - KEY_W'(qs_r * KEY_W'(STEP_MODULUS));
  assign step_raw = STEP_W'(rem_s);
  assign prod_2   = PSW'(step_r) * PSW'(RECIP_TS);
  assign rem_2    = step_r - STEP_W'(q2_r * STEP_W'(TABLE_SIZE));

  assign in_ready   = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);
  assign push_item  = item_r;
  assign push_home  = home_r;
  assign push_step  = SLOT_W'(rem_2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: if (in_valid) begin
          item_r  <= in_item;
          state_r <= F_QUOT;
        end
        F_QUOT: begin
          qh_r    <= prod_h[32 +: KEY_W];
          qs_r    <= prod_s[32 +: KEY_W];
          state_r <= F_REM;
        end
        F_REM: begin
          home_r  <= SLOT_W'(rem_h);
          // zero step would never move off the home slot
          step_r  <= (step_raw == '0) ? STEP_W'(1) : step_raw;
          state_r <= F_QUOT2;
        end
        F_QUOT2: begin
          q2_r    <= prod_2[32 +: STEP_W];
          state_r <= F_PUSH;
        end
        F_PUSH: if (push_ready) begin
          state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// File: design/dht_back.sv
module dht_back #(
  parameter int TABLE_SIZE = 7,
  parameter int SLOT_W     = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  dht_pkg::dht_item_t   pop_item,
  input  logic [SLOT_W-1:0]    pop_home,
  input  logic [SLOT_W-1:0]    pop_step,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dht_pkg::dht_result_t out_res
);

  import dht_pkg::*;

  localparam int JW = $clog2(TABLE_SIZE + 1);
  localparam logic [JW-1:0]     J_END     = JW'(TABLE_SIZE);
  localparam logic [SLOT_W-1:0] PROBE_LAST = SLOT_W'(TABLE_SIZE - 1);
  localparam logic [SLOT_W:0]   TS_WIDE   = (SLOT_W+1)'(TABLE_SIZE);

  typedef enum logic [2:0] {B_IDLE, B_INS, B_DEL, B_RD, B_EMIT} bstate_t;

  bstate_t           state_r;
  logic [TABLE_SIZE-1:0] valid_r;
  dht_item_t         item_r;
  logic              in_range_r;
  logic [SLOT_W-1:0] p_r, step_r, i_r, chk_idx_r;
  logic [JW-1:0]     j_r;
  logic              chk_v_r;
  dht_result_t       res_r, out_r;
  logic              out_valid_r;

  logic [KEY_W-1:0]  key_mem [TABLE_SIZE];
  logic [REC_W-1:0]  rec_mem [TABLE_SIZE];
  logic [KEY_W-1:0]  key_rd_r;
  logic [REC_W-1:0]  rec_rd_r;
  logic [SLOT_W-1:0] raddr, rd_idx;
  logic              mem_we, pop_in_range, del_hit, rd_hit, emit_go;
  logic [SLOT_W:0]   p_sum;
  logic [SLOT_W-1:0] p_next;
  logic [SLOT_FW-1:0] init_idx;
  dht_result_t       res_init;

  assign pop_ready    = (state_r == B_IDLE);
  assign out_valid    = out_valid_r;
  assign out_res      = out_r;

  assign pop_in_range = (32'(pop_item.slot) < TABLE_SIZE);
  assign rd_idx       = pop_in_range ? SLOT_W'(pop_item.slot) : '0;
  assign raddr        = (state_r == B_DEL) ? ((j_r < J_END) ? SLOT_W'(j_r) : '0) : rd_idx;
  assign mem_we       = (state_r == B_INS) && !valid_r[p_r];

  assign p_sum  = {1'b0, p_r} + {1'b0, step_r};
  assign p_next = (p_sum >= TS_WIDE) ? SLOT_W'(p_sum - TS_WIDE) : SLOT_W'(p_sum);

  assign del_hit = chk_v_r && valid_r[chk_idx_r] && (key_rd_r == item_r.key);
  assign rd_hit  = in_range_r && valid_r[p_r];
  assign emit_go = (state_r == B_EMIT) && (!out_valid_r || out_ready);

  // read reports the requested slot index, everything else starts at zero
  assign init_idx = (pop_item.op == OP_READ) ? pop_item.slot : '0;

  always_comb begin
    res_init            = '0;
    res_init.slot_index = init_idx;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[p_r] <= item_r.key;
      rec_mem[p_r] <= item_r.record;
    end
    key_rd_r <= key_mem[raddr];
    rec_rd_r <= rec_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      valid_r     <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: if (pop_valid) begin
          item_r     <= pop_item;
          in_range_r <= pop_in_range;
          step_r     <= pop_step;
          i_r        <= '0;
          j_r        <= '0;
          res_r      <= res_init;
          p_r        <= (pop_item.op == OP_READ) ? rd_idx : pop_home;
          unique case (pop_item.op)
            OP_INSERT: state_r <= B_INS;
            OP_DELETE: state_r <= B_DEL;
            OP_READ:   state_r <= B_RD;
            default:   state_r <= B_EMIT;
          endcase
        end
        B_INS: begin
          priority if (!valid_r[p_r]) begin
            valid_r[p_r]     <= 1'b1;
            res_r.slot_index <= SLOT_FW'(p_r);
            state_r          <= B_EMIT;
          end else if (i_r == PROBE_LAST) begin
            res_r.status <= STATUS_FULL;
            state_r      <= B_EMIT;
          end else begin
            p_r <= p_next;
            i_r <= i_r + 1'b1;
          end
        end
        B_DEL: begin
          // read slot j, compare it in the next cycle
          chk_v_r <= (j_r < J_END);
          if (j_r < J_END) begin
            chk_idx_r <= SLOT_W'(j_r);
            j_r       <= j_r + 1'b1;
          end
          if (del_hit) begin
            valid_r[chk_idx_r] <= 1'b0;
            if (res_r.removed_count != CNT_MAX) begin
              res_r.removed_count <= res_r.removed_count + 1'b1;
            end
          end
          if (j_r == J_END) begin
            if (res_r.removed_count == '0 && !del_hit) begin
              res_r.status <= STATUS_NOT_FOUND;
            end
            state_r <= B_EMIT;
          end
        end
        B_RD: begin
          res_r.slot_valid <= rd_hit;
          res_r.key_out    <= rd_hit ? key_rd_r : '0;
          res_r.record_out <= rd_hit ? rec_rd_r : '0;
          state_r          <= B_EMIT;
        end
        B_EMIT: if (emit_go) begin
          out_r   <= res_r;
          state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// File: design/double_hash_table.sv
// Double-hashing hash table of TABLE_SIZE slots, one result word per request word.
// Op insert probes (key mod TABLE_SIZE + i*step) mod TABLE_SIZE, step = key mod
// STEP_MODULUS (zero taken as 1), writes key and record into the first empty slot
// and returns its index, or status full after TABLE_SIZE probes. Op delete clears
// every valid slot holding the key and returns the count (saturating at 7), or
// status not-found. Op read returns a slot's valid flag, key and record; a slot
// past the table reads empty. Op 3 returns all zeros. Equal keys may be stored
// more than once. The table is empty after reset; there is no clearing pass.
// A front end takes a word and works out home slot and step with reciprocal
// multiplies, then hands it through a 2-word queue to the back end, which owns
// the table. The back end picks up the word, then probes for an insert (one
// slot per cycle), scans every slot for a delete (the key store's registered
// read port scans one slot per cycle), reads the slot for a read and does no
// table work for op 3, then loads the output register. The front end works on
// the next word meanwhile, so back-to-back words are bound by whichever end is
// slower for that word. The output register lets new words enter while a
// result waits on out_ready.
module double_hash_table #(
  parameter int TABLE_SIZE   = 7,
  parameter int STEP_MODULUS = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dht_pkg::OP_W-1:0]       in_op,
  input  logic [dht_pkg::KEY_W-1:0]      in_key,
  input  logic [dht_pkg::REC_W-1:0]      in_record,
  input  logic [dht_pkg::SLOT_FW-1:0]    in_slot,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dht_pkg::STATUS_W-1:0]   out_status,
  output logic [dht_pkg::SLOT_FW-1:0]    out_slot_index,
  output logic                           out_slot_valid,
  output logic [dht_pkg::KEY_W-1:0]      out_key_out,
  output logic [dht_pkg::REC_W-1:0]      out_record_out,
  output logic [dht_pkg::CNT_W-1:0]      out_removed_count
);

  import dht_pkg::*;

  localparam int SLOT_W      = $clog2(TABLE_SIZE);
  localparam int STEP_W      = $clog2(STEP_MODULUS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QW          = 2 * SLOT_W + $bits(dht_item_t);

  dht_item_t         in_item, f_item, q_item;
  logic              f_valid, f_ready, q_valid, q_ready;
  logic [SLOT_W-1:0] f_home, f_step, q_home, q_step;
  logic [QW-1:0]     q_push_data, q_pop_data;
  dht_result_t       res;

  assign in_item = '{op: in_op, key: in_key, record: in_record, slot: in_slot};

  // front: takes words, computes home slot and probe step
  dht_front #(
    .TABLE_SIZE   (TABLE_SIZE),
    .STEP_MODULUS (STEP_MODULUS),
    .SLOT_W       (SLOT_W),
    .STEP_W       (STEP_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .push_home  (f_home),
    .push_step  (f_step)
  );

  assign q_push_data = {f_home, f_step, f_item};
  assign {q_home, q_step, q_item} = q_pop_data;

  // decouples hashing from table access
  dht_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_pop_data)
  );

  // back: owns valid bits and key/record store, runs probe and scan loops
  dht_back #(
    .TABLE_SIZE (TABLE_SIZE),
    .SLOT_W     (SLOT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_item  (q_item),
    .pop_home  (q_home),
    .pop_step  (q_step),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_status        = res.status;
  assign out_slot_index    = res.slot_index;
  assign out_slot_valid    = res.slot_valid;
  assign out_key_out       = res.key_out;
  assign out_record_out    = res.record_out;
  assign out_removed_count = res.removed_count;

endmodule

// File: design/dht_checker.sv
`include "double_hash_table_assert.svh"

module dht_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [dht_pkg::STATUS_W-1:0]   out_status,
  input logic [dht_pkg::SLOT_FW-1:0]    out_slot_index,
  input logic                           out_slot_valid,
  input logic [dht_pkg::KEY_W-1:0]      out_key_out,
  input logic [dht_pkg::REC_W-1:0]      out_record_out,
  input logic [dht_pkg::CNT_W-1:0]      out_removed_count
);

  import dht_pkg::*;

  // front 1 + queue 2 + back 1 + output register 1
  localparam logic [2:0] MAX_INFLIGHT = 3'd5;

  logic [2:0]  inflight_r;
  logic        in_acc, out_acc;
  dht_result_t out_word;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  assign out_word = {out_status, out_slot_index, out_slot_valid, out_key_out,
                     out_record_out, out_removed_count};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + 3'(in_acc) - 3'(out_acc);
    end
  end

  `DHT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
  `DHT_ASSERT_IMP(a_no_spurious, out_valid, inflight_r != 3'd0)
  `DHT_ASSERT_IMP(a_inflight_cap, 1'b1, inflight_r <= MAX_INFLIGHT)
  `DHT_ASSERT_IMP(a_full_clean, out_valid && out_status == STATUS_FULL, out_slot_index == '0 && out_removed_count == '0 && !out_slot_valid)
  `DHT_ASSERT_IMP(a_read_hit, out_valid && out_slot_valid, out_status == STATUS_DONE && out_removed_count == '0)

endmodule

bind double_hash_table dht_checker u_dht_checker (.*);

// File: bench/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dht_pkg::*;

  // Geometry of the block as instantiated below.
  localparam int TBL_SLOTS   = 7;
  localparam int STEP_MOD    = 5;
  // Random words after the directed part.
  localparam int RAND_WORDS  = 1050;
  // Worst case per word is a full send gap, the block's own work and a full
  // receiver stall; the limit leaves several times that for the whole run.
  localparam int CYCLE_LIMIT = 300000;
  // Tail wait after the last reply covers a full front end and back end pass.
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    dht_item_t word;
    bit        hold_for_drain;  // sender waits until no reply is outstanding
  } request_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_op = '0;
  logic [KEY_W-1:0]    in_key = '0;
  logic [REC_W-1:0]    in_record = '0;
  logic [SLOT_FW-1:0]  in_slot = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_FW-1:0]  out_slot_index;
  logic                out_slot_valid;
  logic [KEY_W-1:0]    out_key_out;
  logic [REC_W-1:0]    out_record_out;
  logic [CNT_W-1:0]    out_removed_count;

  double_hash_table #(
    .TABLE_SIZE   (TBL_SLOTS),
    .STEP_MODULUS (STEP_MOD)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_key            (in_key),
    .in_record         (in_record),
    .in_slot           (in_slot),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slot_index    (out_slot_index),
    .out_slot_valid    (out_slot_valid),
    .out_key_out       (out_key_out),
    .out_record_out    (out_record_out),
    .out_removed_count (out_removed_count)
  );

  // Request words waiting to go out, and replies the table must still produce.
  request_t    request_words[$];
  dht_result_t awaited_replies[$];
  int          words_total = 0;
  int          words_accepted = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  // Shadow copy of the table contents.
  bit             shadow_used[TBL_SLOTS];
  logic [KEY_W-1:0] shadow_key[TBL_SLOTS];
  logic [REC_W-1:0] shadow_rec[TBL_SLOTS];

  // Applies one request word to the shadow table and returns the reply it
  // should produce.
  function automatic dht_result_t hash_table_apply(input dht_item_t w);
    dht_result_t r;
    int home, step, p;
    bit placed;
    r = '0;
    placed = 1'b0;
    case (w.op)
      OP_INSERT: begin
        home = int'(w.key) % TBL_SLOTS;
        step = int'(w.key) % STEP_MOD;
        if (step == 0) step = 1;   // zero step would probe one slot forever
        for (int i = 0; i < TBL_SLOTS && !placed; i++) begin
          p = (home + i * step) % TBL_SLOTS;
          if (!shadow_used[p]) begin
            shadow_used[p] = 1'b1;
            shadow_key[p]  = w.key;
            shadow_rec[p]  = w.record;
            r.slot_index   = SLOT_FW'(p);
            placed         = 1'b1;
          end
        end
        if (!placed) r.status = STATUS_FULL;
      end
      OP_DELETE: begin
        // every copy of the key goes, count saturates
        for (int j = 0; j < TBL_SLOTS; j++) begin
          if (shadow_used[j] && shadow_key[j] == w.key) begin
            shadow_used[j] = 1'b0;
            if (r.removed_count != CNT_MAX) r.removed_count++;
          end
        end
        if (r.removed_count == '0) r.status = STATUS_NOT_FOUND;
      end
      OP_READ: begin
        r.slot_index = w.slot;
        // slots past the table read as empty
        if (int'(w.slot) < TBL_SLOTS && shadow_used[w.slot]) begin
          r.slot_valid = 1'b1;
          r.key_out    = shadow_key[w.slot];
          r.record_out = shadow_rec[w.slot];
        end
      end
      default: ;  // unused opcode: all-zero reply, table untouched
    endcase
    return r;
  endfunction

  function automatic void queue_word(input logic [OP_W-1:0] op,
                                     input logic [KEY_W-1:0] key,
                                     input logic [REC_W-1:0] rec,
                                     input logic [SLOT_FW-1:0] slot,
                                     input bit drain);
    request_t rq;
    rq.word.op         = op;
    rq.word.key        = key;
    rq.word.record     = rec;
    rq.word.slot       = slot;
    rq.hold_for_drain  = drain;
    request_words.push_back(rq);
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("[%0t] mismatch on %s: got 0x%0h, wanted 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Compares the word on the result port with the oldest awaited reply.
  task automatic check_reply();
    dht_result_t want;
    if (awaited_replies.size() == 0) begin
      report_mismatch("reply with nothing outstanding (status)", out_status, 0);
      return;
    end
    want = awaited_replies.pop_front();
    if (out_status !== want.status)
      report_mismatch("status", out_status, want.status);
    if (out_slot_index !== want.slot_index)
      report_mismatch("slot_index", out_slot_index, want.slot_index);
    if (out_slot_valid !== want.slot_valid)
      report_mismatch("slot_valid", out_slot_valid, want.slot_valid);
    if (out_key_out !== want.key_out)
      report_mismatch("key_out", out_key_out, want.key_out);
    if (out_record_out !== want.record_out)
      report_mismatch("record_out", out_record_out, want.record_out);
    if (out_removed_count !== want.removed_count)
      report_mismatch("removed_count", out_removed_count, want.removed_count);
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  // Synchronous reset, low at the start and released once, never again.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Sender. A word presented stays put until taken; after each accepted word
  // a random idle gap is drawn, except in quiet stretches with no gaps.
  dht_item_t cur_word = '0;
  request_t  cur_req;
  int        send_gap = 0;
  bit        send_quiet = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = $urandom_range(0, 17);
    end else begin
      if (in_valid && in_ready) begin
        awaited_replies.push_back(hash_table_apply(cur_word));
        words_accepted++;
        send_gap = send_quiet ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_words.size() != 0 &&
                     !(request_words[0].hold_for_drain && awaited_replies.size() != 0)) begin
          cur_req  = request_words.pop_front();
          cur_word = cur_req.word;
          in_valid  <= 1'b1;
          in_op     <= cur_word.op;
          in_key    <= cur_word.key;
          in_record <= cur_word.record;
          in_slot   <= cur_word.slot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. After each reply it stalls for a random spell, with quiet stretches.
  int recv_stall = 0;
  bit recv_quiet = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_reply();
        recv_stall = recv_quiet ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int          key_pool[8];
    int          pool_size;
    int          pick;
    logic [15:0] k;

    // Directed: empty-table reads (one past the end), delete of an absent
    // key, unused opcode with every field at its top.
    queue_word(OP_READ, 16'h0000, 32'h0, 3'd7, 1'b0);
    queue_word(OP_READ, 16'h0000, 32'h0, 3'd0, 1'b0);
    queue_word(OP_DELETE, 16'h0000, 32'h0, 3'd0, 1'b0);
    queue_word(2'd3, 16'hFFFF, 32'hFFFF_FFFF, 3'd7, 1'b0);
    // Key 0 has zero step; seven copies fill every slot.
    queue_word(OP_INSERT, 16'h0000, 32'h0000_0000, 3'd0, 1'b0);
    queue_word(OP_INSERT, 16'h0000, 32'hFFFF_FFFF, 3'd5, 1'b0);
    for (int i = 0; i < 5; i++)
      queue_word(OP_INSERT, 16'h0000, $urandom, 3'($urandom_range(0, 7)), 1'b0);
    // Table full now.
    queue_word(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 3'd0, 1'b0);
    queue_word(OP_READ, 16'h0000, 32'h0, 3'd6, 1'b0);
    queue_word(OP_READ, 16'h0000, 32'h0, 3'd7, 1'b0);
    // Seven copies removed at once: count reaches its ceiling.
    queue_word(OP_DELETE, 16'h0000, 32'h0, 3'd0, 1'b0);
    // Collisions on home slot 1 with steps 1 and 3.
    queue_word(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 3'd0, 1'b0);
    queue_word(OP_INSERT, 16'd36, 32'h1234_5678, 3'd0, 1'b0);
    queue_word(OP_INSERT, 16'd8, 32'h8765_4321, 3'd0, 1'b0);
    queue_word(OP_READ, 16'h0000, 32'h0, 3'd1, 1'b0);
    queue_word(OP_READ, 16'h0000, 32'h0, 3'd4, 1'b0);
    queue_word(OP_DELETE, 16'hFFFF, 32'h0, 3'd0, 1'b0);
    queue_word(OP_DELETE, 16'h5555, 32'h0, 3'd0, 1'b0);

    // Random part. Keys come mostly from a small pool, renewed now and then,
    // so inserts collide, the table fills and deletes find their keys.
    pool_size = 1;
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % 150 == 0) begin
        pool_size = $urandom_range(1, 8);
        for (int j = 0; j < 8; j++)
          key_pool[j] = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 65535);
      end
      if ($urandom_range(0, 9) < 7)
        k = 16'(key_pool[$urandom_range(0, pool_size - 1)]);
      else
        k = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 42)
        queue_word(OP_INSERT, k, $urandom, 3'($urandom_range(0, 7)), n % 300 == 150);
      else if (pick < 67)
        queue_word(OP_DELETE, k, $urandom, 3'($urandom_range(0, 7)), n % 300 == 150);
      else if (pick < 95)
        queue_word(OP_READ, k, $urandom, 3'($urandom_range(0, 7)), n % 300 == 150);
      else
        queue_word(2'd3, k, $urandom, 3'($urandom_range(0, 7)), n % 300 == 150);
    end
    words_total = request_words.size();

    @(posedge rst_n);
    while (words_accepted < words_total || awaited_replies.size() != 0)
      @(posedge clk);
    // Let any stray extra reply show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+design
design/dht_pkg.sv
design/dht_queue.sv
design/dht_front.sv
design/dht_back.sv
design/double_hash_table.sv
design/dht_checker.sv
bench/tb_top.sv
